// ----- src/ring_mac_frame_receiver_assert.svh -----
// Assertion macros for the ring MAC frame receiver.
// No dependencies; included by modules that check their own logic.
`ifndef RING_MAC_FRAME_RECEIVER_ASSERT_SVH
`define RING_MAC_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RMFR_ASSERT_NOW(lbl, clk, rstn, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |-> (cons)) \
        else $error("ring MAC receiver check failed");

// Next-cycle implication, disabled during reset.
`define RMFR_ASSERT_NEXT(lbl, clk, rstn, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |=> (cons)) \
        else $error("ring MAC receiver check failed");

`endif

// ----- src/rmfr_pkg.sv -----
// Types and constants of the ring MAC frame receiver.
// No dependencies; imported by ring_mac_frame_receiver.
package rmfr_pkg;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 5;
    localparam int SVC_W  = 3;
    localparam int IDX_W  = 9;
    localparam int SUM_W  = 6;
    localparam int CFG_IDX_W = 8;

    typedef enum logic [3:0] {
        V_PENDING  = 4'd0,
        V_TOKEN    = 4'd1,
        V_PASSED   = 4'd2,
        V_CHAT     = 4'd3,
        V_TIME     = 4'd4,
        V_OTHER    = 4'd5,
        V_BAD_SUM  = 4'd6,
        V_ACKED    = 4'd7,
        V_UNACKED  = 4'd8,
        V_UNREAD   = 4'd9,
        V_SHORT    = 4'd10
    } verdict_t;

    typedef enum logic [1:0] {
        K_TOKEN  = 2'd0,
        K_OWN    = 2'd1,
        K_PASSED = 2'd2,
        K_LOCAL  = 2'd3
    } kind_t;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_MY_ADDRESS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_TAG    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAT_SERVICE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SERVICE = 8'd3;

    localparam logic [ADDR_W-1:0] MY_ADDRESS_RST   = 5'd0;
    localparam logic [BYTE_W-1:0] TOKEN_TAG_RST    = 8'hFF;
    localparam logic [SVC_W-1:0]  CHAT_SERVICE_RST = 3'd1;
    localparam logic [SVC_W-1:0]  TIME_SERVICE_RST = 3'd3;

    localparam logic [IDX_W-1:0]  HDR_BYTES = 9'd3;    // source, destination, length
    localparam logic [IDX_W-1:0]  IDX_MAX   = 9'd511;
    localparam logic [BYTE_W-1:0] ACK_INC   = 8'h03;
    localparam logic [BYTE_W-1:0] NACK_INC  = 8'h02;
    localparam logic [1:0]        ST_ACKED   = 2'd3;
    localparam logic [1:0]        ST_UNACKED = 2'd2;

endpackage

// ----- src/ring_mac_frame_receiver.sv -----
// Ring MAC frame receiver: routes frame bytes, checks and acknowledges status.
// Depends on rmfr_pkg and ring_mac_frame_receiver_assert.svh.
//
//  channel | direction | payload
//  s_      | in        | tdata: rx_byte; tlast: frame_last
//  m_      | out       | tdata: out_byte, src_address, src_service; tuser: flags, verdict
//  cfg_    | in        | cfg_index, cfg_data; cfg_ready always high
//
// One byte per cycle while the output is taken; each byte passes through the input
// register and then sits in the output register until taken.
// Frame state is a single set of registers updated as a byte moves to the
// output register. Reset is synchronous, active low; clears control and config.
// An output stall holds the input register; s_tready drops only when both hold.
`include "ring_mac_frame_receiver_assert.svh"

module ring_mac_frame_receiver
    import rmfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [7:0] out_byte, [12:8] src_address, [15:13] src_service
    output logic [6:0]           m_tuser,   // [0] to_ring, [1] to_sender, [2] to_app, [6:3] verdict
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    // config
    logic [ADDR_W-1:0] my_address_reg;
    logic [BYTE_W-1:0] token_tag_reg;
    logic [SVC_W-1:0]  chat_service_reg;
    logic [SVC_W-1:0]  time_service_reg;

    // input stage
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // frame state
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0] plen_reg, plen_next;
    kind_t             kind_reg, kind_next;
    logic [ADDR_W-1:0] src_addr_reg, src_addr_next;
    logic [SVC_W-1:0]  src_svc_reg, src_svc_next;

    // output stage
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] ob_reg, ob_next;
    logic              ring_reg, ring_next;
    logic              send_reg, send_next;
    logic              app_reg, app_next;
    verdict_t          verdict_reg, verdict_next;

    logic              out_adv, proc, s_acc;
    logic              idx_first;
    kind_t             kind_now;
    logic [BYTE_W-1:0] plen_now;
    logic [SUM_W-1:0]  sum_now;
    logic [IDX_W-1:0]  status_idx;
    logic              at_status, in_payload, decided;

    assign cfg_ready = 1'b1;
    assign out_adv   = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && out_adv;
    assign s_tready  = !in_valid_reg || out_adv;
    assign s_acc     = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_acc) begin
            in_valid_next = 1'b1;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (proc) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // frame classification and state update for the byte in the input register
    always_comb begin
        idx_first     = (idx_reg == '0);
        src_addr_next = idx_first ? in_byte_reg[7:3] : src_addr_reg;
        src_svc_next  = idx_first ? in_byte_reg[2:0] : src_svc_reg;
        sum_now       = idx_first ? '0 : sum_reg;

        kind_now = kind_reg;
        if (idx_first) begin
            if (in_byte_reg == token_tag_reg) begin
                kind_now = K_TOKEN;
            end else if (in_byte_reg[7:3] == my_address_reg) begin
                kind_now = K_OWN;
            end else begin
                kind_now = K_PASSED;
            end
        end else if (idx_reg == 9'd1 && kind_reg == K_PASSED
                     && in_byte_reg[7:3] == my_address_reg) begin
            kind_now = K_LOCAL;
        end

        if (idx_first) begin
            plen_now = '0;
        end else if (idx_reg == 9'd2) begin
            plen_now = in_byte_reg;
        end else begin
            plen_now = plen_reg;
        end
        status_idx = {1'b0, plen_now} + HDR_BYTES;
        at_status  = (idx_reg == status_idx);
        in_payload = (idx_reg >= HDR_BYTES) && (idx_reg < status_idx);

        ob_next      = in_byte_reg;
        ring_next    = 1'b0;
        send_next    = 1'b0;
        app_next     = 1'b0;
        verdict_next = V_PENDING;
        decided      = 1'b0;
        unique case (kind_now)
            K_TOKEN: begin
                send_next = 1'b1;
                decided   = 1'b1;
                if (idx_first) begin
                    verdict_next = V_TOKEN;
                end
            end
            K_PASSED: begin
                ring_next = 1'b1;
                decided   = !idx_first;
                if (idx_reg == 9'd1) begin
                    verdict_next = V_PASSED;
                end
            end
            K_OWN: begin
                decided = (idx_reg >= status_idx);
                if (at_status) begin
                    case (in_byte_reg[1:0])
                        ST_ACKED:   verdict_next = V_ACKED;
                        ST_UNACKED: verdict_next = V_UNACKED;
                        default:    verdict_next = V_UNREAD;
                    endcase
                end
            end
            default: begin
                ring_next = 1'b1;
                app_next  = in_payload;
                decided   = (idx_reg >= status_idx);
                if (at_status) begin
                    if (sum_now == in_byte_reg[7:2]) begin
                        ob_next = in_byte_reg + ACK_INC;
                        if (src_svc_next == chat_service_reg) begin
                            verdict_next = V_CHAT;
                        end else if (src_svc_next == time_service_reg) begin
                            verdict_next = V_TIME;
                        end else begin
                            verdict_next = V_OTHER;
                        end
                    end else begin
                        ob_next      = in_byte_reg + NACK_INC;
                        verdict_next = V_BAD_SUM;
                    end
                end
            end
        endcase

        if (in_last_reg && !decided) begin
            verdict_next = V_SHORT;
        end

        // status byte itself is excluded from the sum
        sum_next = sum_now;
        if (idx_reg < HDR_BYTES || idx_reg < status_idx) begin
            sum_next = sum_now + in_byte_reg[SUM_W-1:0];
        end
        plen_next = plen_now;
        idx_next  = (idx_reg == IDX_MAX) ? idx_reg : idx_reg + 9'd1;
        kind_next = kind_now;
        if (in_last_reg) begin
            idx_next  = '0;
            sum_next  = '0;
            plen_next = '0;
            kind_next = K_TOKEN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            my_address_reg   <= MY_ADDRESS_RST;
            token_tag_reg    <= TOKEN_TAG_RST;
            chat_service_reg <= CHAT_SERVICE_RST;
            time_service_reg <= TIME_SERVICE_RST;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            idx_reg          <= '0;
            sum_reg          <= '0;
            plen_reg         <= '0;
            kind_reg         <= K_TOKEN;
            src_addr_reg     <= '0;
            src_svc_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MY_ADDRESS:   my_address_reg   <= cfg_data[ADDR_W-1:0];
                    CFG_TOKEN_TAG:    token_tag_reg    <= cfg_data;
                    CFG_CHAT_SERVICE: chat_service_reg <= cfg_data[SVC_W-1:0];
                    CFG_TIME_SERVICE: time_service_reg <= cfg_data[SVC_W-1:0];
                    default: ;
                endcase
            end
            if (proc) begin
                idx_reg      <= idx_next;
                sum_reg      <= sum_next;
                plen_reg     <= plen_next;
                kind_reg     <= kind_next;
                src_addr_reg <= src_addr_next;
                src_svc_reg  <= src_svc_next;
            end
        end
    end

    // payload registers
    logic [ADDR_W-1:0] out_addr_reg;
    logic [SVC_W-1:0]  out_svc_reg;

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc) begin
            ob_reg       <= ob_next;
            ring_reg     <= ring_next;
            send_reg     <= send_next;
            app_reg      <= app_next;
            verdict_reg  <= verdict_next;
            out_addr_reg <= src_addr_next;
            out_svc_reg  <= src_svc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_svc_reg, out_addr_reg, ob_reg};
    assign m_tuser  = {verdict_reg, app_reg, send_reg, ring_reg};

    // a token byte never also goes to the ring or the application
    `RMFR_ASSERT_NOW(a_token_exclusive, aclk, aresetn,
        m_tvalid && m_tuser[1], !m_tuser[0] && !m_tuser[2])
    // payload delivered here is also forwarded on the ring
    `RMFR_ASSERT_NOW(a_app_on_ring, aclk, aresetn, m_tvalid && m_tuser[2], m_tuser[0])
    // only the status byte of a local frame is modified
    `RMFR_ASSERT_NOW(a_byte_unchanged, aclk, aresetn,
        proc && (ob_next != in_byte_reg), (kind_now == K_LOCAL) && at_status)
    // a last byte restarts the frame
    `RMFR_ASSERT_NEXT(a_frame_restart, aclk, aresetn,
        proc && in_last_reg, (idx_reg == '0) && (sum_reg == '0) && (plen_reg == '0))

endmodule

// ----- bench/ring_mac_frame_receiver_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for ring_mac_frame_receiver: directed frames, then random frames.
// Depends on rmfr_pkg and the RTL; predicts routed bytes in its own model unless a row is typed.
module ring_mac_frame_receiver_test;
    import rmfr_pkg::*;

    localparam int           HOLD_CYCLES    = 300;
    localparam int           WATCHDOG_LIMIT = 3000;
    localparam int           MAX_REPORTS    = 10;
    localparam int           HEADER_LEN     = 3;
    localparam int           INDEX_TOP      = 511;
    localparam logic [7:0]   ACK_STEP       = 8'h03;
    localparam logic [7:0]   NACK_STEP      = 8'h02;
    localparam logic [1:0]   STATUS_ACKED   = 2'b11;
    localparam logic [1:0]   STATUS_UNACKED = 2'b10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       to_ring;
        logic       to_sender;
        logic       to_app;
        verdict_t   verdict;
        logic [4:0] src_addr;
        logic [2:0] src_svc;
    } route_t;

    // typed rows carry their own expected route instead of the predicted one
    typedef struct packed {
        logic   typed;
        route_t want;
    } note_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fix;    // replace bits 7..2 with the frame's running sum
        logic       typed;
        route_t     want;
    } row_t;

    localparam route_t NO_WANT = '0;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [7:0] rx_byte
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;   // [7:0] out_byte, [12:8] src_address, [15:13] src_service
    logic [6:0]           m_tuser;   // [0] to_ring, [1] to_sender, [2] to_app, [6:3] verdict
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    ring_mac_frame_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // station registers as the predictor sees them
    logic [4:0] cfg_my   = MY_ADDRESS_RST;
    logic [7:0] cfg_tag  = TOKEN_TAG_RST;
    logic [2:0] cfg_chat = CHAT_SERVICE_RST;
    logic [2:0] cfg_time = TIME_SERVICE_RST;

    // frame tracking state of the predictor
    logic [8:0] st_idx   = '0;
    logic [5:0] st_sum   = '0;
    logic [7:0] st_len   = '0;
    kind_t      st_kind  = K_TOKEN;
    logic [4:0] st_saddr = '0;
    logic [2:0] st_ssvc  = '0;

    route_t     predicted_routes[$];
    note_t      tx_notes[$];
    logic [7:0] frame_q[$];
    logic       fix_q[$];

    int         items_sent   = 0;
    int         results_seen = 0;
    int         fail_count   = 0;
    int         idle_cycles  = 0;
    int         burst_left   = 0;
    bit         eager        = 1'b0;
    bit         hold_pending = 1'b0;
    int         hold_left    = 0;
    logic [5:0] frame_sum    = '0;

    localparam int DIR_ROWS = 26;
    row_t dir_rows [DIR_ROWS] = '{
        // token tag alone: verdict on byte 0, fields show the tag bits
        '{8'hFF, 1'b1, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b1, 1'b0, V_TOKEN, 5'd31, 3'd7}},
        // own frame, acknowledged
        '{8'h05, 1'b0, 1'b0, 1'b1, '{8'h05, 1'b0, 1'b0, 1'b0, V_PENDING, 5'd0, 3'd5}},
        '{8'h48, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'h03, 1'b1, 1'b0, 1'b1, '{8'h03, 1'b0, 1'b0, 1'b0, V_ACKED, 5'd0, 3'd5}},
        // own frame, not acknowledged
        '{8'h02, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'h10, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'hFE, 1'b1, 1'b0, 1'b1, '{8'hFE, 1'b0, 1'b0, 1'b0, V_UNACKED, 5'd0, 3'd2}},
        // own frame, not read
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'h01, 1'b1, 1'b0, 1'b1, '{8'h01, 1'b0, 1'b0, 1'b0, V_UNREAD, 5'd0, 3'd0}},
        // frame ends before its deciding byte
        '{8'h30, 1'b1, 1'b0, 1'b1, '{8'h30, 1'b1, 1'b0, 1'b0, V_SHORT, 5'd6, 3'd0}},
        // passed frame, decided on byte 1
        '{8'h5A, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'h88, 1'b1, 1'b0, 1'b1, '{8'h88, 1'b1, 1'b0, 1'b0, V_PASSED, 5'd11, 3'd2}},
        // local chat frame with good sum and a byte after the status
        '{8'h21, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'h03, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'h01, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'h10, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_WANT},
        '{8'h55, 1'b1, 1'b0, 1'b0, NO_WANT},
        // local frame with bad sum, status wraps past 255
        '{8'h0B, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'h07, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{8'hFF, 1'b1, 1'b0, 1'b1, '{8'h01, 1'b1, 1'b0, 1'b0, V_BAD_SUM, 5'd1, 3'd3}}
    };

    // routes one received byte and advances the frame state
    function automatic route_t route_byte(input logic [7:0] b, input logic last);
        route_t     r;
        logic [8:0] idx;
        logic [8:0] status_at;
        bit         decided;
        idx = st_idx;
        r = NO_WANT;
        r.out_byte = b;
        if (idx == 0) begin
            st_saddr = b[7:3];
            st_ssvc  = b[2:0];
            st_sum   = '0;
            st_len   = '0;
            if (b == cfg_tag)
                st_kind = K_TOKEN;
            else if (b[7:3] == cfg_my)
                st_kind = K_OWN;
            else
                st_kind = K_PASSED;
        end
        if (idx == 1 && st_kind == K_PASSED && b[7:3] == cfg_my)
            st_kind = K_LOCAL;
        if (idx == 2)
            st_len = b;
        status_at = {1'b0, st_len} + 9'(HEADER_LEN);
        case (st_kind)
            K_TOKEN: begin
                r.to_sender = 1'b1;
                if (idx == 0)
                    r.verdict = V_TOKEN;
                decided = 1'b1;
            end
            K_PASSED: begin
                r.to_ring = 1'b1;
                if (idx == 1)
                    r.verdict = V_PASSED;
                decided = idx >= 1;
            end
            K_OWN: begin
                if (idx >= HEADER_LEN && idx == status_at) begin
                    if (b[1:0] == STATUS_ACKED)
                        r.verdict = V_ACKED;
                    else if (b[1:0] == STATUS_UNACKED)
                        r.verdict = V_UNACKED;
                    else
                        r.verdict = V_UNREAD;
                end
                decided = idx >= HEADER_LEN && idx >= status_at;
            end
            default: begin
                r.to_ring = 1'b1;
                if (idx >= HEADER_LEN && idx < status_at)
                    r.to_app = 1'b1;
                if (idx >= HEADER_LEN && idx == status_at) begin
                    if (st_sum == b[7:2]) begin
                        r.out_byte = b + ACK_STEP;
                        if (st_ssvc == cfg_chat)
                            r.verdict = V_CHAT;
                        else if (st_ssvc == cfg_time)
                            r.verdict = V_TIME;
                        else
                            r.verdict = V_OTHER;
                    end else begin
                        r.out_byte = b + NACK_STEP;
                        r.verdict  = V_BAD_SUM;
                    end
                end
                decided = idx >= HEADER_LEN && idx >= status_at;
            end
        endcase
        if (idx < HEADER_LEN || idx < status_at)
            st_sum = st_sum + b[5:0];
        if (last && !decided)
            r.verdict = V_SHORT;
        r.src_addr = st_saddr;
        r.src_svc  = st_ssvc;
        if (last) begin
            st_idx  = '0;
            st_sum  = '0;
            st_len  = '0;
            st_kind = K_TOKEN;
        end else if (idx < INDEX_TOP) begin
            st_idx = idx + 9'd1;
        end
        return r;
    endfunction

    // predicts at input acceptance, checks at output acceptance, watches for a hang
    always @(posedge aclk) begin : watch
        route_t got;
        route_t want;
        note_t  note;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                note = (tx_notes.size() != 0) ? tx_notes.pop_front() : '0;
                want = route_byte(s_tdata, s_tlast);
                predicted_routes.push_back(note.typed ? note.want : want);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.out_byte  = m_tdata[7:0];
                got.src_addr  = m_tdata[12:8];
                got.src_svc   = m_tdata[15:13];
                got.to_ring   = m_tuser[0];
                got.to_sender = m_tuser[1];
                got.to_app    = m_tuser[2];
                got.verdict   = verdict_t'(m_tuser[6:3]);
                if (predicted_routes.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: unexpected transaction out=%h", $realtime, m_tdata);
                    fail_count++;
                end else begin
                    want = predicted_routes.pop_front();
                    if (got.out_byte !== want.out_byte || got.to_ring !== want.to_ring ||
                        got.to_sender !== want.to_sender || got.to_app !== want.to_app ||
                        got.verdict !== want.verdict || got.src_addr !== want.src_addr ||
                        got.src_svc !== want.src_svc) begin
                        if (fail_count < MAX_REPORTS)
                            $display({"%0t: mismatch exp out=%h ring=%b snd=%b app=%b v=%0d ",
                                      "sa=%0d ss=%0d, got out=%h ring=%b snd=%b app=%b v=%0d ",
                                      "sa=%0d ss=%0d"}, $realtime,
                                     want.out_byte, want.to_ring, want.to_sender, want.to_app,
                                     want.verdict, want.src_addr, want.src_svc,
                                     got.out_byte, got.to_ring, got.to_sender, got.to_app,
                                     got.verdict, got.src_addr, got.src_svc);
                        fail_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ring_mac_frame_receiver regression: fail");
                $finish;
            end
        end
    end

    // output backpressure: random modes, plus one long hold on request
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int cyc          = 0;
    always @(posedge aclk) begin
        cyc++;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_pending || hold_left > 0) begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(32, 256);
            end
            rx_mode_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 9) < 7);
                2:       m_tready <= ($urandom_range(0, 9) < 3);
                default: m_tready <= (cyc % 5 < 3);
            endcase
        end
    end

    task automatic send_item(input logic [7:0] data, input logic last, input logic fix,
                             input logic typed, input route_t want);
        int    gap;
        note_t note;
        if (fix)
            data[7:2] = frame_sum;
        if (!eager) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                repeat (gap) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                end
            end
            burst_left--;
        end
        note.typed = typed;
        note.want  = want;
        tx_notes.push_back(note);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        frame_sum = last ? 6'd0 : frame_sum + data[5:0];
    endtask

    // stop offering and wait for every routed byte to come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge aclk);
    endtask

    task automatic write_regs(input logic [4:0] my, input logic [7:0] tag,
                              input logic [2:0] chat, input logic [2:0] tsvc);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [7:0]           val [4];
        idx[0] = CFG_MY_ADDRESS;   val[0] = {3'd0, my};
        idx[1] = CFG_TOKEN_TAG;    val[1] = tag;
        idx[2] = CFG_CHAT_SERVICE; val[2] = {5'd0, chat};
        idx[3] = CFG_TIME_SERVICE; val[3] = {5'd0, tsvc};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cfg_my   = my;
        cfg_tag  = tag;
        cfg_chat = chat;
        cfg_time = tsvc;
    endtask

    function automatic void add_byte(input logic [7:0] b, input logic fix);
        frame_q.push_back(b);
        fix_q.push_back(fix);
    endfunction

    // passed frame of n bytes with random content, used for fill-up and index saturation
    function automatic void build_run(input int n);
        frame_q.delete();
        fix_q.delete();
        add_byte({cfg_my + 5'($urandom_range(1, 31)), 3'($urandom)}, 1'b0);
        add_byte({cfg_my + 5'($urandom_range(1, 31)), 3'($urandom)}, 1'b0);
        repeat (n - 2) add_byte(8'($urandom), 1'b0);
    endfunction

    function automatic void build_frame();
        int         pick;
        int         r;
        int         len;
        int         cut;
        int         s;
        logic [2:0] svc;
        frame_q.delete();
        fix_q.delete();
        pick = $urandom_range(0, 99);
        r = $urandom_range(0, 99);
        len = (r < 85) ? $urandom_range(0, 6) : (r < 97) ? $urandom_range(7, 40)
                                                         : $urandom_range(41, 255);
        if (pick < 8) begin
            add_byte(cfg_tag, 1'b0);
            repeat ($urandom_range(0, 5)) add_byte(8'($urandom), 1'b0);
        end else if (pick < 92) begin
            if (pick < 30) begin
                // own frame
                add_byte({cfg_my, 3'($urandom)}, 1'b0);
                add_byte(8'($urandom), 1'b0);
            end else begin
                s = $urandom_range(0, 2);
                svc = (s == 0) ? cfg_chat : (s == 1) ? cfg_time : 3'($urandom);
                add_byte({cfg_my + 5'($urandom_range(1, 31)), svc}, 1'b0);
                if (pick < 48)
                    add_byte({cfg_my + 5'($urandom_range(1, 31)), 3'($urandom)}, 1'b0);
                else
                    add_byte({cfg_my, 3'($urandom)}, 1'b0);
            end
            add_byte(8'(len), 1'b0);
            repeat (len) add_byte(8'($urandom), 1'b0);
            // status byte: mostly a good sum on local frames
            add_byte(8'($urandom), pick >= 48 && $urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) add_byte(8'($urandom), 1'b0);
        end else begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom), 1'b0);
        end
        if (frame_q.size() > 1 && $urandom_range(0, 99) < 8) begin
            cut = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > cut) begin
                void'(frame_q.pop_back());
                void'(fix_q.pop_back());
            end
        end
    endfunction

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_item(frame_q[i], i == frame_q.size() - 1, fix_q[i], 1'b0, NO_WANT);
    endtask

    task automatic random_phase(input int n_items, input bit with_hold, input bit with_long);
        int start;
        start = items_sent;
        while (items_sent - start < n_items) begin
            if (with_hold && items_sent - start > n_items / 2) begin
                // receiver stops while the sender keeps offering, so the input stalls
                hold_pending = 1'b1;
                eager = 1'b1;
                build_run(60);
                send_frame();
                eager = 1'b0;
                with_hold = 1'b0;
            end
            if (with_long && items_sent - start > n_items / 3) begin
                build_run(530);
                send_frame();
                with_long = 1'b0;
            end
            if ($urandom_range(0, 49) == 0)
                drain();
            build_frame();
            send_frame();
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MY_ADDRESS;
        cfg_data  = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset register values first
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i].data, dir_rows[i].last, dir_rows[i].fix,
                      dir_rows[i].typed, dir_rows[i].want);
        random_phase(250, 1'b0, 1'b0);

        drain();
        write_regs(5'd31, 8'h00, 3'd7, 3'd0);
        random_phase(360, 1'b1, 1'b0);

        drain();
        write_regs(5'd0, 8'hFF, 3'd0, 3'd7);
        random_phase(360, 1'b0, 1'b1);

        // equal services: chat takes precedence
        drain();
        write_regs(5'($urandom), 8'($urandom), 3'd5, 3'd5);
        random_phase(200, 1'b0, 1'b0);

        drain();
        write_regs(5'($urandom), 8'($urandom), 3'($urandom), 3'($urandom));
        random_phase(200, 1'b0, 1'b0);

        drain();
        repeat (8) @(posedge aclk);
        if (predicted_routes.size() != 0) begin
            $display("%0d routed bytes never came out", predicted_routes.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("ring_mac_frame_receiver regression: pass");
        else
            $display("ring_mac_frame_receiver regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/rmfr_pkg.sv
src/ring_mac_frame_receiver.sv
bench/ring_mac_frame_receiver_test.sv
